FILE: src/rgba_box_downsample_2x2_defines.svh
// ---------------------------------------------------------------------------
// rgba_box_downsample_2x2 assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef RGBA_BOX_DOWNSAMPLE_2X2_DEFINES_SVH
`define RGBA_BOX_DOWNSAMPLE_2X2_DEFINES_SVH

// same-cycle implication
`define RBD_ASSERT_NOW(label, cond, check, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (check)) \
        else $error(msg);

// next-cycle implication
`define RBD_ASSERT_NEXT(label, cond, check, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (check)) \
        else $error(msg);

`endif

FILE: src/rbd_pkg.sv
// ---------------------------------------------------------------------------
// rbd_pkg
// Types, constants and channel arithmetic of the 2x2 box downsampler.
// ---------------------------------------------------------------------------
package rbd_pkg;

    localparam int CFG_W      = 13;
    localparam int CH_W       = 8;
    localparam int PAIR_CH_W  = 9;
    localparam logic [CFG_W-1:0] EDGE_RESET = 13'd256;
    localparam logic [10:0] ROUND_BIAS = 11'd2;

    typedef logic [CH_W-1:0] t_chan;

    typedef struct packed {
        t_chan alpha;
        t_chan blue;
        t_chan green;
        t_chan red;
    } t_pix;

    // horizontal pair sums, 9 bits a channel
    typedef struct packed {
        logic [PAIR_CH_W-1:0] alpha;
        logic [PAIR_CH_W-1:0] blue;
        logic [PAIR_CH_W-1:0] green;
        logic [PAIR_CH_W-1:0] red;
    } t_pair;

    typedef struct packed {
        logic emit;   // item reads the line store and yields a result
        logic last;   // final output pixel of the face
    } t_issue;

    function automatic t_pair pair_of(input t_pix a, input t_pix b);
        t_pair s;
        s.red   = {1'b0, a.red}   + {1'b0, b.red};
        s.green = {1'b0, a.green} + {1'b0, b.green};
        s.blue  = {1'b0, a.blue}  + {1'b0, b.blue};
        s.alpha = {1'b0, a.alpha} + {1'b0, b.alpha};
        return s;
    endfunction

    function automatic t_chan round_quarter(input logic [PAIR_CH_W-1:0] a,
                                            input logic [PAIR_CH_W-1:0] b);
        logic [10:0] t;
        t = 11'({1'b0, a}) + 11'({1'b0, b}) + ROUND_BIAS;
        return t[9:2];
    endfunction

    function automatic t_pix box_round(input t_pair a, input t_pair b);
        t_pix p;
        p.red   = round_quarter(a.red,   b.red);
        p.green = round_quarter(a.green, b.green);
        p.blue  = round_quarter(a.blue,  b.blue);
        p.alpha = round_quarter(a.alpha, b.alpha);
        return p;
    endfunction

endpackage

FILE: src/rbd_cfg_if.sv
// ---------------------------------------------------------------------------
// rbd_cfg_if
// Configuration write channel: source edge length.
// ---------------------------------------------------------------------------
interface rbd_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [rbd_pkg::CFG_W-1:0] source_edge;

    modport source (output valid, output source_edge, input ready);
    modport sink   (input valid, input source_edge, output ready);
endinterface

FILE: src/rbd_pix_if.sv
// ---------------------------------------------------------------------------
// rbd_pix_if
// Source pixel channel, one RGBA8 pixel an item.
// ---------------------------------------------------------------------------
interface rbd_pix_if;
    logic                    valid;
    logic                    ready;
    logic [rbd_pkg::CH_W-1:0] red_in;
    logic [rbd_pkg::CH_W-1:0] green_in;
    logic [rbd_pkg::CH_W-1:0] blue_in;
    logic [rbd_pkg::CH_W-1:0] alpha_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output alpha_in, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input alpha_in, output ready);
endinterface

FILE: src/rbd_res_if.sv
// ---------------------------------------------------------------------------
// rbd_res_if
// Result channel, one downsampled pixel an item.
// ---------------------------------------------------------------------------
interface rbd_res_if;
    logic                    valid;
    logic                    ready;
    logic [rbd_pkg::CH_W-1:0] red_out;
    logic [rbd_pkg::CH_W-1:0] green_out;
    logic [rbd_pkg::CH_W-1:0] blue_out;
    logic [rbd_pkg::CH_W-1:0] alpha_out;
    logic                    face_done;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output alpha_out, output face_done, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input alpha_out, input face_done, output ready);
endinterface

FILE: src/rbd_line_store.sv
// ---------------------------------------------------------------------------
// rbd_line_store
// Line store of pair sums, one write or one registered read a cycle.
// ---------------------------------------------------------------------------
module rbd_line_store #(
    parameter int DEPTH = 2048,
    parameter int IW    = 11
) (
    input  logic           i_clk,
    input  logic           i_we,
    input  logic           i_re,
    input  logic [IW-1:0]  i_addr,
    input  rbd_pkg::t_pair i_wdata,
    output rbd_pkg::t_pair o_rdata
);

    rbd_pkg::t_pair r_mem [DEPTH];
    rbd_pkg::t_pair r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/rbd_scan.sv
// ---------------------------------------------------------------------------
// rbd_scan
// Raster counters, horizontal pairing and line store access control.
// ---------------------------------------------------------------------------
module rbd_scan #(
    parameter int MAX_EDGE = 4096,
    parameter int CW       = 12,
    parameter int EW       = 13,
    parameter int IW       = 11
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [rbd_pkg::CFG_W-1:0] i_cfg_edge,
    input  logic                      i_accept,
    input  rbd_pkg::t_pix             i_pix,
    output logic                      o_wr_en,
    output logic                      o_rd_en,
    output logic [IW-1:0]             o_addr,
    output rbd_pkg::t_pair            o_pair,
    output rbd_pkg::t_issue           o_iss
);

    logic [CW-1:0]  r_col;
    logic [CW-1:0]  r_row;
    logic [EW-1:0]  r_edge;       // effective edge, clamped to 1..MAX_EDGE
    logic [EW-1:0]  r_last_odd;   // last odd index of an even-trimmed edge
    rbd_pkg::t_pix  r_acc;

    logic [CW-1:0]  n_col;
    logic [CW-1:0]  n_row;
    logic [EW-1:0]  col_inc;
    logic [EW-1:0]  row_inc;
    logic           pair_item;

    function automatic logic [EW-1:0] clamp_edge(input logic [rbd_pkg::CFG_W-1:0] d);
        logic [EW-1:0] e;
        if (d == '0) begin
            e = EW'(1);
        end else if (32'(d) > MAX_EDGE) begin
            e = EW'(MAX_EDGE);
        end else begin
            e = EW'(d);
        end
        return e;
    endfunction

    function automatic logic [EW-1:0] last_odd_of(input logic [EW-1:0] e);
        return {e[EW-1:1], 1'b0} - EW'(1);
    endfunction

    always_comb begin
        col_inc   = EW'(r_col) + EW'(1);
        row_inc   = EW'(r_row) + EW'(1);
        n_col     = CW'(col_inc);
        n_row     = r_row;
        if (col_inc >= r_edge) begin
            n_col = '0;
            n_row = (row_inc >= r_edge) ? '0 : CW'(row_inc);
        end
        pair_item = i_accept && r_col[0];
    end

    assign o_pair    = rbd_pkg::pair_of(r_acc, i_pix);
    assign o_addr    = IW'(r_col >> 1);
    assign o_wr_en   = pair_item && !r_row[0];
    assign o_rd_en   = pair_item && r_row[0];
    assign o_iss.emit = o_rd_en;
    assign o_iss.last = (EW'(r_col) == r_last_odd) && (EW'(r_row) == r_last_odd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_acc      <= '0;
            r_edge     <= clamp_edge(rbd_pkg::EDGE_RESET);
            r_last_odd <= last_odd_of(clamp_edge(rbd_pkg::EDGE_RESET));
        end else if (i_cfg_we) begin
            r_edge     <= clamp_edge(i_cfg_edge);
            r_last_odd <= last_odd_of(clamp_edge(i_cfg_edge));
            r_col      <= '0;
            r_row      <= '0;
        end else if (i_accept) begin
            if (!r_col[0]) begin
                r_acc <= i_pix;
            end
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

FILE: src/rbd_out_stage.sv
// ---------------------------------------------------------------------------
// rbd_out_stage
// Vertical add with rounding and the output register.
// ---------------------------------------------------------------------------
module rbd_out_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rbd_pkg::t_issue i_iss,
    input  rbd_pkg::t_pair  i_pair,
    input  rbd_pkg::t_pair  i_rdata,
    input  logic            i_out_ready,
    output logic            o_valid,
    output rbd_pkg::t_pix   o_pix,
    output logic            o_done,
    output logic            o_block
);

    logic           r_s1_valid;
    rbd_pkg::t_pair r_s1_pair;
    logic           r_s1_last;
    logic           r_out_valid;
    rbd_pkg::t_pix  r_out_pix;
    logic           r_out_last;
    logic           s1_move;

    // s1 waits for the store data, then moves on once the output slot frees
    assign s1_move = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_block = r_s1_valid && r_out_valid && !i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_iss.emit) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_iss.emit) begin
            r_s1_pair <= i_pair;
            r_s1_last <= i_iss.last;
        end
        if (s1_move) begin
            r_out_pix  <= rbd_pkg::box_round(r_s1_pair, i_rdata);
            r_out_last <= r_s1_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_pix   = r_out_pix;
    assign o_done  = r_out_last;

endmodule

FILE: src/rgba_box_downsample_2x2.sv
// ---------------------------------------------------------------------------
// rgba_box_downsample_2x2
// Takes a square RGBA8 face in row-major order, one pixel an item, and gives
// the next coarser mip level, one pixel for every 2x2 source block, each
// channel the rounded mean (sum of four plus two, over four). The block takes
// one pixel every cycle while no result waits behind a stalled output; the
// figure is set by the single line store port, which sees at most one access
// per pixel (a write on even rows, a read on odd rows, only on odd columns),
// and by the output register. Each result passes the s1 and output registers.
// face_done marks the last result of the face. A trailing odd row or column
// gives nothing and an edge of one gives no result at all. Writing source_edge
// (clamped to 1..MAX_EDGE) restarts the raster at column 0, row 0; write it
// only while idle. The line store needs no clearing after reset: an entry is
// always written on an even row before the odd row below reads it.
// ---------------------------------------------------------------------------
`include "rgba_box_downsample_2x2_defines.svh"

module rgba_box_downsample_2x2 #(
    parameter int MAX_EDGE = 4096
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rbd_cfg_if.sink   i_cfg,
    rbd_pix_if.sink   i_pix,
    rbd_res_if.source o_res
);

    localparam int DEPTH = MAX_EDGE / 2;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_EDGE);
    localparam int EW    = $clog2(MAX_EDGE + 1);

    logic            pix_accept;
    logic            block;
    logic            st_wr_en;
    logic            st_rd_en;
    logic [IW-1:0]   st_addr;
    rbd_pkg::t_pair  pair_sum;
    rbd_pkg::t_pair  above;
    rbd_pkg::t_issue iss;
    rbd_pkg::t_pix   pix;
    rbd_pkg::t_pix   res_pix;

    // register writes are always taken
    assign i_cfg.ready = 1'b1;

    // input stalls only when a read result is waiting behind a full output
    assign i_pix.ready = !block;
    assign pix_accept  = i_pix.valid && i_pix.ready;

    assign pix.red   = i_pix.red_in;
    assign pix.green = i_pix.green_in;
    assign pix.blue  = i_pix.blue_in;
    assign pix.alpha = i_pix.alpha_in;

    // stage 0: counters, horizontal pair, store access
    rbd_scan #(
        .MAX_EDGE (MAX_EDGE),
        .CW       (CW),
        .EW       (EW),
        .IW       (IW)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_edge (i_cfg.source_edge),
        .i_accept   (pix_accept),
        .i_pix      (pix),
        .o_wr_en    (st_wr_en),
        .o_rd_en    (st_rd_en),
        .o_addr     (st_addr),
        .o_pair     (pair_sum),
        .o_iss      (iss)
    );

    // pair sums of the even row above, indexed by column / 2
    rbd_line_store #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_wr_en),
        .i_re    (st_rd_en),
        .i_addr  (st_addr),
        .i_wdata (pair_sum),
        .o_rdata (above)
    );

    // stage 1: vertical add, rounding, output register
    rbd_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_iss       (iss),
        .i_pair      (pair_sum),
        .i_rdata     (above),
        .i_out_ready (o_res.ready),
        .o_valid     (o_res.valid),
        .o_pix       (res_pix),
        .o_done      (o_res.face_done),
        .o_block     (block)
    );

    assign o_res.red_out   = res_pix.red;
    assign o_res.green_out = res_pix.green;
    assign o_res.blue_out  = res_pix.blue;
    assign o_res.alpha_out = res_pix.alpha;

    // single port: never a write and a read together
    `RBD_ASSERT_NOW(a_store_one_access, st_wr_en, !st_rd_en, "line store write and read together")
    // store accesses happen on odd columns only, so two in a row mean a counter slip
    `RBD_ASSERT_NEXT(a_store_spacing, st_wr_en || st_rd_en, !st_wr_en && !st_rd_en,
                     "line store accessed on consecutive cycles")
    // input holds off only while the output is full and stalled
    `RBD_ASSERT_NOW(a_stall_cause, !i_pix.ready, o_res.valid && !o_res.ready,
                    "input stalled without output back-pressure")

endmodule
